// ===== sv/fwg_pkg.sv =====
package fwg_pkg;

  localparam int SineTableDepthDef = 256;
  localparam int PhaseBitsDef      = 32;
  localparam int OutputBitsDef     = 16;

  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  // (2k)(2k+1) for the odd powers of the series
  localparam logic [8:0] TaylorDiv [9] = '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110,
                                           9'd156, 9'd210, 9'd272, 9'd342};

  typedef enum logic [1:0] {
    MODE_SQUARE     = 2'd0,
    MODE_SINE       = 2'd1,
    MODE_SINE_PHASE = 2'd2
  } mode_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_MODE          = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_PHASE_OFFSET  = 3'd2,
    REG_SQUARE_PERIOD = 3'd3,
    REG_FRAME_TOTAL   = 3'd4
  } cfg_reg_e;

  // quarter-wave sine in q30 from angle x in q30, truncated taylor series
  function automatic logic [30:0] sine_entry(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = x;
    term = x;
    for (int k = 0; k < 9; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'(TaylorDiv[k]);
      if ((k % 2) == 0) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > OneQ30) begin
      sum = OneQ30;
    end
    return sum[30:0];
  endfunction

endpackage

// ===== sv/flicker_waveform_generator_core.sv =====
// pipeline: a frame tick's result passes the stage 1 rom read register, then the output register
// throughput: one frame tick per cycle while the output is not stalled, set by the registered sine rom read
//   feeding a single level/scale stage and the output register
// reset: config returns to defaults (square mode, period 2), run state idle;
//   the sine rom is constant and needs no clearing pass
module flicker_waveform_generator_core
  import fwg_pkg::*;
#(
  parameter int SineTableDepth = SineTableDepthDef,
  parameter int PhaseBits      = PhaseBitsDef,
  parameter int OutputBits     = OutputBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RegIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OutputBits-1:0] intensity_o,
  output logic                  last_o
);

  localparam int IdxW  = $clog2(SineTableDepth + 1);
  localparam int ProdW = PhaseBits - 2 + IdxW;
  localparam int WideW = 32 + OutputBits;

  // sine rom, constant contents
  logic [30:0] sine_rom [SineTableDepth+1];

  for (genvar gi = 0; gi <= SineTableDepth; gi++) begin : g_rom
    localparam logic [63:0] RomX   = (HalfPiQ30 * 64'(gi)) / 64'(SineTableDepth);
    localparam logic [30:0] RomVal = sine_entry(RomX);
    assign sine_rom[gi] = RomVal;
  end

  // config
  logic [1:0]  mode_q;
  logic [31:0] step_q;
  logic [15:0] offset_q;
  logic [15:0] period_q;
  logic [15:0] total_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SQUARE;
      step_q   <= '0;
      offset_q <= '0;
      period_q <= 16'd2;
      total_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:          mode_q   <= cfg_data_i[1:0];
        REG_PHASE_STEP:    step_q   <= cfg_data_i;
        REG_PHASE_OFFSET:  offset_q <= cfg_data_i[15:0];
        REG_SQUARE_PERIOD: period_q <= cfg_data_i[15:0];
        REG_FRAME_TOTAL:   total_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // run state
  logic [15:0]          cnt_q, cnt_d;
  logic [PhaseBits-1:0] acc_q, acc_d;
  logic [15:0]          pos_q, pos_d;
  logic                 running_q, running_d;

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv, s1_ready, in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // stage 0
  logic [15:0]          cnt_c, pos_c, period_c;
  logic [PhaseBits-1:0] acc_c, step_al, phase;
  logic                 run_c, produce, is_last, sq_on;
  logic [16:0]          pos_inc;
  logic [ProdW-1:0]     idx_prod;
  logic [IdxW-1:0]      idx, rom_addr;

  if (PhaseBits >= 32) begin : g_step_up
    assign step_al = PhaseBits'(step_q) << (PhaseBits - 32);
  end else begin : g_step_down
    assign step_al = PhaseBits'(step_q >> (32 - PhaseBits));
  end

  always_comb begin
    cnt_c    = restart_i ? '0 : cnt_q;
    acc_c    = restart_i ? '0 : acc_q;
    pos_c    = restart_i ? '0 : pos_q;
    run_c    = restart_i || running_q;
    produce  = run_c && (cnt_c < total_q);
    is_last  = ({1'b0, cnt_c} + 17'd1) == {1'b0, total_q};
    period_c = (period_q == '0) ? 16'd1 : period_q;
    sq_on    = pos_c < (period_c >> 1);
    pos_inc  = {1'b0, pos_c} + 17'd1;

    phase = acc_c;
    if (mode_q == MODE_SINE_PHASE) begin
      phase = acc_c + (PhaseBits'(offset_q) << (PhaseBits - 16));
    end
    idx_prod = ProdW'(phase[PhaseBits-3:0]) * ProdW'(SineTableDepth);
    idx      = idx_prod[ProdW-1 -: IdxW];
    rom_addr = phase[PhaseBits-2] ? IdxW'(SineTableDepth) - idx : idx;

    cnt_d     = cnt_c;
    acc_d     = acc_c;
    pos_d     = pos_c;
    running_d = produce && !is_last;
    if (produce) begin
      cnt_d = cnt_c + 16'd1;
      acc_d = acc_c + step_al;
      pos_d = (pos_inc >= {1'b0, period_c}) ? '0 : pos_inc[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      acc_q     <= '0;
      pos_q     <= '0;
      running_q <= 1'b0;
    end else if (in_acc) begin
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      running_q <= running_d;
    end
  end

  // stage 1 payload, rom read
  logic        s1_sine_q, s1_neg_q, s1_on_q, s1_last_q;
  logic [30:0] rom_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sine_q <= (mode_q != MODE_SQUARE);
      s1_neg_q  <= phase[PhaseBits-1];
      s1_on_q   <= sq_on;
      s1_last_q <= is_last;
      rom_q     <= sine_rom[rom_addr];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = in_acc && produce;
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // level and scale: level * (2^n - 1) rounded, shifted down by 31
  logic [31:0]           level;
  logic [WideW-1:0]      wide;
  logic [OutputBits-1:0] sine_out, intensity_d;
  logic [OutputBits-1:0] intensity_q;
  logic                  last_q;

  always_comb begin
    level = s1_neg_q ? 32'(OneQ30) - {1'b0, rom_q} : 32'(OneQ30) + {1'b0, rom_q};
    wide  = ({level, {OutputBits{1'b0}}} - WideW'(level)) + WideW'(OneQ30);
    sine_out = wide[30+OutputBits:31];
    if (s1_sine_q) begin
      intensity_d = sine_out;
    end else begin
      intensity_d = s1_on_q ? {OutputBits{1'b1}} : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      intensity_q <= intensity_d;
      last_q      <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign intensity_o = intensity_q;
  assign last_o      = last_q;

endmodule

// ===== sv/fwg_checker.sv =====
module fwg_checker
  import fwg_pkg::*;
#(
  parameter int OutputBits = OutputBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [OutputBits-1:0] intensity_o,
  input logic                  last_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(intensity_o) && $stable(last_o))
    else $error("stalled result word changed");

  // back-pressure only when the output register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // a fresh result comes from an accepted frame tick that passed the stage 1 and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without a matching frame tick");

endmodule

bind flicker_waveform_generator_core fwg_checker #(
  .OutputBits(OutputBits)
) u_fwg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .intensity_o(intensity_o),
  .last_o     (last_o)
);

// ===== bench/fwg_frame_checker.sv =====
`timescale 1ns / 100ps

module fwg_frame_checker
  import fwg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [RegIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [OutputBitsDef-1:0] intensity_i,
  input  logic                     last_i,
  output int                       mismatches_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       lasts_o
);

  localparam int          TableDepth     = SineTableDepthDef;
  localparam logic [63:0] QuarterTurnQ30 = 64'd1686629713;
  localparam logic [63:0] UnityQ30       = 64'd1073741824;
  localparam logic [63:0] FullLevel      = (64'd1 << OutputBitsDef) - 64'd1;

  typedef struct packed {
    logic [OutputBitsDef-1:0] level;
    logic                     last_frame;
  } frame_word_t;

  logic [63:0] quarter_sine [TableDepth+1];
  frame_word_t due_frames [$];

  logic [1:0]  cfg_mode;
  logic [31:0] cfg_step;
  logic [15:0] cfg_offset;
  logic [15:0] cfg_period;
  logic [15:0] cfg_total;

  logic [15:0] frame_idx;
  logic [31:0] phase_acc;
  logic [15:0] sq_pos;
  logic        active;

  int errs;
  int checked;
  int lasts;

  // quarter-wave table in q30, truncated taylor series in integer steps
  initial begin : build_quarter_sine
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    int          i;
    int          k;
    for (i = 0; i <= TableDepth; i++) begin
      x    = (QuarterTurnQ30 * 64'(i)) / 64'(TableDepth);
      sum  = x;
      term = x;
      for (k = 1; k <= 9; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / (64'(2 * k) * 64'(2 * k + 1));
        if ((k % 2) == 1) begin
          sum = (sum > term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      quarter_sine[i] = (sum > UnityQ30) ? UnityQ30 : sum;
    end
  end

  function automatic logic [OutputBitsDef-1:0] sine_intensity(input logic [31:0] ph);
    logic [63:0] idx;
    logic [63:0] s;
    logic [63:0] lvl;
    logic [63:0] scaled;
    idx    = ({34'd0, ph[29:0]} * 64'(TableDepth)) >> 30;
    s      = ph[30] ? quarter_sine[64'(TableDepth) - idx] : quarter_sine[idx];
    lvl    = ph[31] ? UnityQ30 - s : UnityQ30 + s;
    scaled = (lvl * FullLevel + UnityQ30) >> 31;
    return scaled[OutputBitsDef-1:0];
  endfunction

  task automatic advance_frame(input logic rs);
    logic [16:0]  period;
    logic [16:0]  nxt;
    logic [31:0]  ph;
    frame_word_t  w;
    if (rs) begin
      active    = 1'b1;
      frame_idx = '0;
      phase_acc = '0;
      sq_pos    = '0;
    end
    if (!active) return;
    if (frame_idx >= cfg_total) begin
      active = 1'b0;
      return;
    end
    period = (cfg_period == '0) ? 17'd1 : {1'b0, cfg_period};
    if (cfg_mode == MODE_SQUARE) begin
      w.level = ({1'b0, sq_pos} < (period >> 1)) ? FullLevel[OutputBitsDef-1:0] : '0;
    end else begin
      ph = phase_acc;
      if (cfg_mode == MODE_SINE_PHASE) begin
        ph = ph + {cfg_offset, 16'h0000};
      end
      w.level = sine_intensity(ph);
    end
    w.last_frame = (({1'b0, frame_idx} + 17'd1) == {1'b0, cfg_total});
    due_frames.push_back(w);
    phase_acc = phase_acc + cfg_step;
    nxt       = {1'b0, sq_pos} + 17'd1;
    sq_pos    = (nxt >= period) ? 16'd0 : nxt[15:0];
    frame_idx = frame_idx + 16'd1;
    if (w.last_frame) begin
      active = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    errs++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : score
    frame_word_t want;
    if (!rst_ni) begin
      cfg_mode   = MODE_SQUARE;
      cfg_step   = '0;
      cfg_offset = '0;
      cfg_period = 16'd2;
      cfg_total  = '0;
      frame_idx  = '0;
      phase_acc  = '0;
      sq_pos     = '0;
      active     = 1'b0;
      due_frames.delete();
      errs       = 0;
      checked    = 0;
      lasts      = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      lasts_o      <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (last_i) lasts++;
        if (due_frames.size() == 0) begin
          errs++;
          $display("%0t: word with nothing expected, intensity %0d last %0b",
                   $time, intensity_i, last_i);
        end else begin
          want = due_frames.pop_front();
          if (intensity_i !== want.level) begin
            note_mismatch("intensity", 64'(want.level), 64'(intensity_i));
          end
          if (last_i !== want.last_frame) begin
            note_mismatch("last", 64'(want.last_frame), 64'(last_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_frame(restart_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:          cfg_mode   = cfg_data_i[1:0];
          REG_PHASE_STEP:    cfg_step   = cfg_data_i[31:0];
          REG_PHASE_OFFSET:  cfg_offset = cfg_data_i[15:0];
          REG_SQUARE_PERIOD: cfg_period = cfg_data_i[15:0];
          REG_FRAME_TOTAL:   cfg_total  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      mismatches_o <= errs;
      pending_o    <= due_frames.size();
      checked_o    <= checked;
      lasts_o      <= lasts;
    end
  end

endmodule

// ===== bench/flicker_waveform_generator_core_tb.sv =====
`timescale 1ns / 100ps

module flicker_waveform_generator_core_tb
  import fwg_pkg::*;
;

  localparam logic [RegIdxW-1:0] RegSpare    = 3'd7;
  localparam logic [1:0]         ModeSpare   = 2'd3;
  localparam int                 TargetItems = 1400;
  localparam int                 DrainCycles = 4;
  localparam int                 LongHold    = 80;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [RegIdxW-1:0]       cfg_index = '0;
  logic [CfgDataW-1:0]      cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     restart   = 1'b0;
  logic                     out_stall = 1'b0;
  logic                     hold_req  = 1'b0;
  logic                     cfg_ready;
  logic                     in_stall;
  logic                     out_valid;
  logic [OutputBitsDef-1:0] intensity;
  logic                     last;

  int          mismatches;
  int          pending;
  int          checked;
  int          lasts;
  int          items_sent   = 0;
  int unsigned tx_calm      = 0;
  bit          sender_eager = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flicker_waveform_generator_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .intensity_o (intensity),
    .last_o      (last)
  );

  fwg_frame_checker i_frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .restart_i    (restart),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .intensity_i  (intensity),
    .last_i       (last),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .lasts_o      (lasts)
  );

  // mostly no gap, some short gaps, a few long ones, and now and then a calm stretch
  task automatic draw_gap(inout int unsigned calm, output int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    span = 0;
    if (calm != 0) begin
      calm--;
    end else if (roll < 1) begin
      calm = $urandom_range(30, 150);
    end else if (roll < 30) begin
      span = $urandom_range(1, 3);
    end else if (roll < 36) begin
      span = $urandom_range(4, 10);
    end else if (roll < 38) begin
      span = $urandom_range(20, 50);
    end
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic rs);
    int unsigned span;
    draw_gap(tx_calm, span);
    if (sender_eager) span = 0;
    if (span != 0) begin
      in_valid <= 1'b0;
      repeat (span) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [15:0] pick_total();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin : receiver
    int unsigned rx_calm;
    int unsigned span;
    bit          served;
    rx_calm = 0;
    served  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !served) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        served = 1'b1;
        out_stall <= 1'b0;
      end else begin
        draw_gap(rx_calm, span);
        if (span != 0) begin
          out_stall <= 1'b1;
          repeat (span) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  mode_pick;
    logic [15:0] total;
    int unsigned len;
    int unsigned j;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // settings after reset: no frames, so restart gives nothing
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // odd square period, upper data bits masked off
    write_reg(REG_FRAME_TOTAL, 32'hFFFF_0006);
    write_reg(REG_SQUARE_PERIOD, 32'd5);
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    settle();

    // quarter-cycle steps visit every quadrant
    write_reg(REG_MODE, 32'(MODE_SINE));
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_FRAME_TOTAL, 32'd5);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    settle();

    // full step and offset, restart in the middle of a run
    write_reg(REG_MODE, 32'(MODE_SINE_PHASE));
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_PHASE_OFFSET, 32'h0000_FFFF);
    write_reg(REG_FRAME_TOTAL, 32'd4);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // unused mode runs as plain sine, spare index is dropped
    write_reg(REG_MODE, 32'(ModeSpare));
    write_reg(REG_PHASE_OFFSET, 32'hFFFF_4000);
    write_reg(REG_PHASE_STEP, 32'h1234_5679);
    write_reg(RegSpare, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // zero square period stays dark
    write_reg(REG_MODE, 32'(MODE_SQUARE));
    write_reg(REG_SQUARE_PERIOD, 32'd0);
    write_reg(REG_FRAME_TOTAL, 32'd3);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // longest period and frame total while the output side holds off
    write_reg(REG_SQUARE_PERIOD, 32'h0000_FFFF);
    write_reg(REG_FRAME_TOTAL, 32'h0000_FFFF);
    sender_eager = 1'b1;
    hold_req <= 1'b1;
    send_tick(1'b1);
    repeat (99) send_tick(1'b0);
    sender_eager = 1'b0;
    settle();

    while (items_sent < TargetItems) begin
      mode_pick = 2'($urandom_range(0, 3));
      total     = pick_total();
      write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFFC) | 32'(mode_pick));
      if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE_STEP, pick_step());
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_PHASE_OFFSET, ($urandom() & 32'hFFFF_0000)
                                    | ($urandom_range(0, 2) == 0 ? 32'h0000_FFFF
                                                                 : 32'($urandom_range(0, 65535))));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_SQUARE_PERIOD, ($urandom() & 32'hFFFF_0000) | 32'(pick_period()));
      end
      write_reg(REG_FRAME_TOTAL, ($urandom() & 32'hFFFF_0000) | 32'(total));
      if ($urandom_range(0, 9) == 0) write_reg(RegSpare, $urandom());

      if (total == 16'd0 || total == 16'hFFFF) begin
        len = $urandom_range(2, 30);
      end else begin
        len = 32'(total) + $urandom_range(0, 3);
      end
      for (j = 0; j < len; j++) begin
        if (j == 0) begin
          send_tick($urandom_range(0, 9) != 0);
        end else begin
          send_tick($urandom_range(0, 39) == 0);
        end
      end
      settle();
    end

    repeat (DrainCycles) @(negedge clk);
    $display("ran %0d frame ticks across square, sine and offset sine settings", items_sent);
    $display("checked %0d intensity words, %0d of them closing a run", checked, lasts);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
